// ===== rtl/ledsfe_pkg.sv =====
`default_nettype none

package ledsfe_pkg;

   // item action codes
   typedef enum logic [2:0] {
      ACT_CMD   = 3'd0,
      ACT_WRITE = 3'd1,
      ACT_READ  = 3'd2,
      ACT_CLEAR = 3'd3,
      ACT_TICK  = 3'd4
   } action_type;

   // frame kinds, same codes as the start actions
   typedef enum logic [1:0] {
      FRM_CMD   = 2'd0,
      FRM_WRITE = 2'd1,
      FRM_READ  = 2'd2,
      FRM_CLEAR = 2'd3
   } frame_type;

   // frame id bits sent ahead of each frame
   localparam logic [2:0] ID_CMD   = 3'b100;
   localparam logic [2:0] ID_WRITE = 3'b101;
   localparam logic [2:0] ID_READ  = 3'b110;
   localparam int unsigned ID_BITS  = 3;
   localparam int unsigned CMD_BITS = 8;
   localparam int unsigned CMD_FRAME_LEN = 12;

   // fixed port widths
   localparam int unsigned READ_DATA_W = 12;
   localparam int unsigned EXT_W       = 16;

   // one result word
   typedef struct packed {
      logic                   accepted;
      logic                   chip_select;
      logic                   write_strobe;
      logic                   read_strobe;
      logic                   data_out;
      logic                   data_driven;
      logic                   frame_end;
      logic                   read_valid;
      logic [READ_DATA_W-1:0] read_data;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/ledsfe_seq.sv =====
`default_nettype none

module ledsfe_seq #(
   parameter int unsigned DATA_BITS    = 12,
   parameter int unsigned ADDRESS_BITS = 7,
   parameter int unsigned CLEAR_BYTES  = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [2:0]             action,
   input  wire logic [7:0]             command,
   input  wire logic [6:0]             address,
   input  wire logic [11:0]            write_data,
   input  wire logic                   data_in,
   output ledsfe_pkg::result_type      result
);

   localparam int unsigned HDR_BITS  = ledsfe_pkg::ID_BITS + ADDRESS_BITS;
   localparam int unsigned SEND_W    = HDR_BITS + DATA_BITS;
   localparam int unsigned CLEAR_LEN = HDR_BITS + 8 * CLEAR_BYTES;
   localparam int unsigned DATA_LEN  = HDR_BITS + DATA_BITS;
   localparam int unsigned MAX_LEN   = (CLEAR_LEN > DATA_LEN) ? CLEAR_LEN : DATA_LEN;
   localparam int unsigned IDX_W     = $clog2(MAX_LEN + 1);
   localparam int unsigned CMD_SHIFT = SEND_W - ledsfe_pkg::ID_BITS - ledsfe_pkg::CMD_BITS;

   localparam logic [IDX_W-1:0] HDR_IDX   = IDX_W'(HDR_BITS);
   localparam logic [IDX_W-1:0] CMD_IDX   = IDX_W'(ledsfe_pkg::CMD_FRAME_LEN);
   localparam logic [IDX_W-1:0] DATA_IDX  = IDX_W'(DATA_LEN);
   localparam logic [IDX_W-1:0] CLEAR_IDX = IDX_W'(CLEAR_LEN);

   ledsfe_pkg::frame_type kind_ff, kind_in;
   logic                  busy_ff, busy_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic [SEND_W-1:0]     send_ff, send_in;
   logic [DATA_BITS-1:0]  read_ff, read_in;

   ledsfe_pkg::action_type act;
   logic [ledsfe_pkg::EXT_W-1:0] addr_ext, wdat_ext, rd_ext;
   logic [ADDRESS_BITS-1:0] addr_use;
   logic [DATA_BITS-1:0]    wdat_use, read_shifted;
   logic [IDX_W-1:0]        index_next, frame_len;
   logic                    read_tick, done;

   assign act      = ledsfe_pkg::action_type'(action);
   assign addr_ext = ledsfe_pkg::EXT_W'(address);
   assign wdat_ext = ledsfe_pkg::EXT_W'(write_data);
   assign addr_use = addr_ext[ADDRESS_BITS-1:0];
   assign wdat_use = wdat_ext[DATA_BITS-1:0];

   // frame length by kind
   always_comb begin
      case (kind_ff)
         ledsfe_pkg::FRM_CMD:   frame_len = CMD_IDX;
         ledsfe_pkg::FRM_WRITE: frame_len = DATA_IDX;
         ledsfe_pkg::FRM_READ:  frame_len = DATA_IDX;
         default:               frame_len = CLEAR_IDX;
      endcase
   end

   // tick bookkeeping
   assign index_next   = index_ff + IDX_W'(1);
   assign done         = index_next >= frame_len;
   assign read_tick    = (kind_ff == ledsfe_pkg::FRM_READ) && (index_ff >= HDR_IDX);
   assign read_shifted = {read_ff[DATA_BITS-2:0], data_in};
   assign rd_ext       = ledsfe_pkg::EXT_W'(read_shifted);

   // action decode, next state and result
   always_comb begin
      kind_in  = kind_ff;
      busy_in  = busy_ff;
      index_in = index_ff;
      send_in  = send_ff;
      read_in  = read_ff;
      result   = '0;
      unique case (act) inside
         ledsfe_pkg::ACT_CMD, ledsfe_pkg::ACT_WRITE,
         ledsfe_pkg::ACT_READ, ledsfe_pkg::ACT_CLEAR: begin
            if (!busy_ff) begin
               case (act)
                  ledsfe_pkg::ACT_CMD:
                     send_in = SEND_W'({ledsfe_pkg::ID_CMD, command}) << CMD_SHIFT;
                  ledsfe_pkg::ACT_WRITE:
                     send_in = SEND_W'({ledsfe_pkg::ID_WRITE, addr_use, wdat_use});
                  ledsfe_pkg::ACT_READ:
                     send_in = SEND_W'({ledsfe_pkg::ID_READ, addr_use}) << DATA_BITS;
                  default:
                     send_in = SEND_W'(ledsfe_pkg::ID_WRITE) << (SEND_W - ledsfe_pkg::ID_BITS);
               endcase
               kind_in         = ledsfe_pkg::frame_type'(action[1:0]);
               busy_in         = 1'b1;
               index_in        = '0;
               read_in         = '0;
               result.accepted = 1'b1;
            end
         end
         ledsfe_pkg::ACT_TICK: begin
            if (busy_ff) begin
               result.chip_select = 1'b1;
               if (read_tick) begin
                  result.read_strobe = 1'b1;
                  read_in            = read_shifted;
               end else begin
                  result.write_strobe = 1'b1;
                  result.data_out     = send_ff[SEND_W-1];
                  result.data_driven  = 1'b1;
                  send_in             = {send_ff[SEND_W-2:0], 1'b0};
               end
               index_in = index_next;
               if (done) begin
                  result.frame_end = 1'b1;
                  busy_in          = 1'b0;
                  if (kind_ff == ledsfe_pkg::FRM_READ) begin
                     result.read_valid = 1'b1;
                     result.read_data  = rd_ext[ledsfe_pkg::READ_DATA_W-1:0];
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= ledsfe_pkg::FRM_CMD;
         busy_ff  <= 1'b0;
         index_ff <= '0;
         send_ff  <= '0;
         read_ff  <= '0;
      end else if (step) begin
         kind_ff  <= kind_in;
         busy_ff  <= busy_in;
         index_ff <= index_in;
         send_ff  <= send_in;
         read_ff  <= read_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/led_driver_serial_frame_engine_unit.sv =====
`default_nettype none

// Serial frame engine for a three-wire LED matrix controller. A start word
// (command, write, read or clear) loads a frame and each tick word then
// drives or samples one serial bit, reporting chip select, write and read
// strobes, the data level and pin direction. Each word is decoded against
// the frame state in the cycle it is accepted and its result sits in one
// output register, so a new word is taken each cycle while that register is
// empty or being drained. A start during a frame is refused with accepted
// low.
module led_driver_serial_frame_engine_unit #(
   parameter int unsigned DATA_BITS    = 12,
   parameter int unsigned ADDRESS_BITS = 7,
   parameter int unsigned CLEAR_BYTES  = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_command,
   input  wire logic [6:0]  req_address,
   input  wire logic [11:0] req_write_data,
   input  wire logic        req_data_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_accepted,
   output logic             rsp_chip_select,
   output logic             rsp_write_strobe,
   output logic             rsp_read_strobe,
   output logic             rsp_data_out,
   output logic             rsp_data_driven,
   output logic             rsp_frame_end,
   output logic             rsp_read_valid,
   output logic [11:0]      rsp_read_data
);

   ledsfe_pkg::result_type result, rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   step;

   // take a word whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   ledsfe_seq #(
      .DATA_BITS    (DATA_BITS),
      .ADDRESS_BITS (ADDRESS_BITS),
      .CLEAR_BYTES  (CLEAR_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .action     (req_action),
      .command    (req_command),
      .address    (req_address),
      .write_data (req_write_data),
      .data_in    (req_data_in),
      .result     (result)
   );

   // output valid
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_chip_select  = rsp_ff.chip_select;
   assign rsp_write_strobe = rsp_ff.write_strobe;
   assign rsp_read_strobe  = rsp_ff.read_strobe;
   assign rsp_data_out     = rsp_ff.data_out;
   assign rsp_data_driven  = rsp_ff.data_driven;
   assign rsp_frame_end    = rsp_ff.frame_end;
   assign rsp_read_valid   = rsp_ff.read_valid;
   assign rsp_read_data    = rsp_ff.read_data;

endmodule

`default_nettype wire
